FILE: rtl/ffsr_pkg.sv
// Package: shared types and constants for the fast float square root pipeline.
package ffsr_pkg;

    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam int          RAD_W     = 48;
    localparam int          REM_W     = 26;
    localparam int          ROOT_W    = 24;
    localparam int          EXP_W     = 8;
    localparam int          FRAC_W    = 23;
    localparam int          STEPS     = 3;
    localparam int          NUM_STAGE = ROOT_W / STEPS;

    // Work carried between root stages
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [EXP_W-1:0]  expo;
    } work_t;

endpackage

FILE: rtl/ffsr_if.sv
// Interfaces: operand and root channels with valid/ready handshake.
interface ffsr_operand_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_bits;
    modport source (output valid, output operand_bits, input ready);
    modport sink (input valid, input operand_bits, output ready);
endinterface

interface ffsr_root_if;
    logic        valid;
    logic        ready;
    logic [30:0] root_bits;
    modport source (output valid, output root_bits, input ready);
    modport sink (input valid, input root_bits, output ready);
endinterface

FILE: rtl/ffsr_stage.sv
// Root stage: three digit-by-digit square root steps, then a register.
module ffsr_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  ffsr_pkg::work_t in_work,
    output logic           valid_reg,
    output ffsr_pkg::work_t work_reg
);

    ffsr_pkg::work_t work_next;

    always_comb
    begin
        logic [ffsr_pkg::REM_W+1:0] shifted;
        logic [ffsr_pkg::REM_W+1:0] trial;
        work_next = in_work;
        for (int s = 0; s < ffsr_pkg::STEPS; s++)
        begin
            shifted = {work_next.rem, work_next.rad[ffsr_pkg::RAD_W-1 -: 2]};
            trial   = {2'b00, work_next.root, 2'b01};
            work_next.rad = {work_next.rad[ffsr_pkg::RAD_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                shifted        = shifted - trial;
                work_next.root = {work_next.root[ffsr_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                work_next.root = {work_next.root[ffsr_pkg::ROOT_W-2:0], 1'b0};
            end
            work_next.rem = shifted[ffsr_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

endmodule

FILE: rtl/fast_float_square_root.sv
// Top level: pipelined approximate single-precision square root.
//
// Channels: operand (sink) takes a 32-bit IEEE single word in operand_bits;
// result (source) gives the 31-bit root word in root_bits (sign always 0).
// A transaction completes at a rising edge with valid and ready both high.
//
// Pipeline: ten registers from operand to root_bits: one prep register
// (exponent and radicand), eight root stages of three restoring square root
// steps each, and one rounding/output register.
// Throughput: one transaction per cycle while result.ready is not held low, set by the per-stage root steps.
//
// Stalls: each stage advances when it is empty or its successor advances,
// so bubbles are squeezed out and a stalled result holds in the output
// register; operand.ready drops only when every stage holds an item.
// Reset clears all valid bits; data registers are not reset.
// Zero, negatives, denormals, infinities and NaNs follow the same formula.
module fast_float_square_root
#(
    parameter int KEPT_FRACTION_BITS = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    ffsr_operand_if.sink       operand,
    ffsr_root_if.source        result
);

    localparam int K      = KEPT_FRACTION_BITS;
    localparam int SH_ODD = 46 - K;
    localparam int NS     = ffsr_pkg::NUM_STAGE;

    // Valid bits and advance enables: index 0 prep, 1..NS root, NS+1 output
    logic [NS+1:0]   valid;
    logic [NS+1:0]   advance;
    ffsr_pkg::work_t work [NS+1];

    // ---- prep: exponent and radicand ----
    logic [31:0]                  diff;
    logic [31:0]                  half;
    logic [31:0]                  biased;
    logic [K:0]                   mant;
    logic [ffsr_pkg::RAD_W-1:0]   rad_odd;
    ffsr_pkg::work_t              prep_next;
    ffsr_pkg::work_t              prep_reg;
    logic                         prep_valid_reg;

    always_comb
    begin
        diff    = operand.operand_bits - ffsr_pkg::ONE_BITS;
        half    = {diff[31], diff[31:1]};
        biased  = half + ffsr_pkg::ONE_BITS;
        mant    = {1'b1, operand.operand_bits[22 -: K]};
        rad_odd = ffsr_pkg::RAD_W'(mant) << SH_ODD;
        prep_next.expo = biased[30:23];
        prep_next.rem  = '0;
        prep_next.root = '0;
        // Exponent bit clear: radicand doubles
        prep_next.rad  = operand.operand_bits[23] ? rad_odd
                                                  : {rad_odd[ffsr_pkg::RAD_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (advance[0])
        begin
            prep_valid_reg <= operand.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            prep_reg <= prep_next;
        end
    end

    assign valid[0] = prep_valid_reg;
    assign work[0]  = prep_reg;

    // ---- root stages ----
    for (genvar g = 1; g <= NS; g++)
    begin : g_stage
        ffsr_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance[g]),
            .in_valid  (valid[g-1]),
            .in_work   (work[g-1]),
            .valid_reg (valid[g]),
            .work_reg  (work[g])
        );
    end

    // ---- rounding and output register ----
    logic                          out_valid_reg;
    logic [30:0]                   root_bits_reg;
    logic [ffsr_pkg::ROOT_W-1:0]   rounded;

    always_comb
    begin
        // Round up when remainder exceeds root (no ties possible)
        rounded = work[NS].root
                + ffsr_pkg::ROOT_W'(ffsr_pkg::REM_W'(work[NS].root) < work[NS].rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance[NS+1])
        begin
            out_valid_reg <= valid[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[NS+1])
        begin
            root_bits_reg <= {work[NS].expo, rounded[ffsr_pkg::FRAC_W-1:0]};
        end
    end

    assign valid[NS+1] = out_valid_reg;

    // Advance a stage when it is empty or its successor moves
    always_comb
    begin
        advance[NS+1] = !valid[NS+1] || result.ready;
        for (int i = NS; i >= 0; i--)
        begin
            advance[i] = !valid[i] || advance[i+1];
        end
    end

    assign operand.ready    = advance[0];
    assign result.valid     = out_valid_reg;
    assign result.root_bits = root_bits_reg;

    // ---- assertions ----
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !operand.ready |-> (&valid))
        else $error("operand blocked while pipeline has a bubble");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (operand.valid && operand.ready) |=> valid[0])
        else $error("accepted transaction missing from prep stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid[NS] && result.valid && !result.ready) |=> valid[NS])
        else $error("last root stage dropped an item under stall");

endmodule

FILE: bench/fast_float_square_root_test.sv
// Testbench for the pipelined approximate single-precision square root.
module fast_float_square_root_test;

    localparam int KEPT        = 15;
    localparam int LATENCY     = 10;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    ffsr_operand_if operand ();
    ffsr_root_if    result ();

    fast_float_square_root #(.KEPT_FRACTION_BITS(KEPT)) u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .result  (result)
    );

    // Expected root words, oldest first
    logic [30:0] pending_roots[$];
    int          error_count;
    int          cycle_count;
    bit          hold_off;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Round-to-nearest integer root of a value below 2^48
    function automatic logic [63:0] nearest_root(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = n;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (rem > res)
            res = res + 64'd1;
        return res;
    endfunction

    // Exponent from halved biased difference; fraction from the kept bits
    function automatic logic [30:0] predict_root(input logic [31:0] x);
        logic [31:0] diff;
        logic [31:0] half;
        logic [31:0] expo;
        logic [63:0] rad;
        logic [63:0] root;
        diff = x - ffsr_pkg::ONE_BITS;
        half = {diff[31], diff[31:1]};
        expo = (half + ffsr_pkg::ONE_BITS) & 32'h7F80_0000;
        rad  = (64'd1 << KEPT) + 64'(x[22 -: KEPT]);
        if (x[23])
            rad = rad << (46 - KEPT);
        else
            rad = rad << (47 - KEPT);
        root = nearest_root(rad);
        return expo[30:0] | {8'd0, root[22:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [30:0] got,
                                   input logic [30:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Send one operand; hold valid across back-to-back transactions
    task automatic send_operand(input logic [31:0] x, input logic [30:0] known,
                                input bit has_known);
        operand.valid        <= 1'b1;
        operand.operand_bits <= x;
        @(posedge clk);
        while (!operand.ready)
            @(posedge clk);
        if (has_known && known !== predict_root(x))
            report_mismatch("table row", predict_root(x), known);
        pending_roots.push_back(predict_root(x));
    endtask

    task automatic idle_cycles(input int n);
        operand.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Receiver: random stall pattern, plus one long hold-off
    initial
    begin
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                result.ready <= 1'b0;
            else if (cycle_count % 400 < 150)
                result.ready <= 1'b1;
            else
                result.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_roots.size() == 0)
                report_mismatch("unexpected result", result.root_bits, 31'd0);
            else
            begin
                if (result.root_bits !== pending_roots[0])
                    report_mismatch("root_bits", result.root_bits, pending_roots[0]);
                void'(pending_roots.pop_front());
            end
        end
    end

    // Count cycles, stage the long hold-off, and stop a hung run
    initial
    begin
        cycle_count = 0;
        hold_off    = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == 600)
                hold_off = 1'b1;
            if (cycle_count == 660)
                hold_off = 1'b0;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout with %0d results outstanding", pending_roots.size());
                $display("fast_float_square_root regression: fail");
                $finish;
            end
        end
    end

    typedef struct {
        logic [31:0] x;
        logic [30:0] known;
        bit          has_known;
    } stim_row_t;

    stim_row_t rows[] = '{
        '{32'h3F80_0000, 31'h3F80_0000, 1'b1},  // one
        '{32'h4080_0000, 31'h4000_0000, 1'b1},  // four
        '{32'h0000_0000, 31'h0, 1'b0},          // zero
        '{32'h8000_0000, 31'h0, 1'b0},          // negative zero
        '{32'hBF80_0000, 31'h0, 1'b0},          // negative
        '{32'h0000_0001, 31'h0, 1'b0},          // smallest denormal
        '{32'h007F_FFFF, 31'h0, 1'b0},          // largest denormal
        '{32'h0080_0000, 31'h0, 1'b0},          // smallest normal
        '{32'h7F7F_FFFF, 31'h0, 1'b0},          // largest normal
        '{32'h7F80_0000, 31'h0, 1'b0},          // infinity
        '{32'hFF80_0000, 31'h0, 1'b0},          // negative infinity
        '{32'h7FC0_0000, 31'h0, 1'b0},          // quiet NaN
        '{32'h7F80_0001, 31'h0, 1'b0},          // signaling NaN
        '{32'hFFFF_FFFF, 31'h0, 1'b0},          // all ones
        '{32'h4000_0000, 31'h0, 1'b0},          // two, even exponent bit clear
        '{32'h3FFF_FFFF, 31'h0, 1'b0},          // just below two
        '{32'h4040_00FF, 31'h0, 1'b0},          // dropped fraction bits set
        '{32'h5555_5555, 31'h0, 1'b0},
        '{32'hAAAA_AAAA, 31'h0, 1'b0}
    };

    // Sender: directed table, then random bursts with gaps
    initial
    begin
        logic [31:0] x;
        int          sent;
        int          burst;
        error_count          = 0;
        operand.valid        <= 1'b0;
        operand.operand_bits <= '0;
        rst_n                = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_operand(rows[i].x, rows[i].known, rows[i].has_known);
        idle_cycles(1);

        // Pause until every expected result has come
        while (pending_roots.size() != 0)
            @(posedge clk);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = (cycle_count % 500 > 550) ? 1 : $urandom_range(1, 40);
            repeat (burst)
            begin
                case ($urandom_range(0, 3))
                    0: x = $urandom();
                    1: x = {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                            8'($urandom_range(0, 255)), 23'($urandom())};
                    2: x = {1'b0, 8'($urandom_range(100, 154)), 23'($urandom())};
                    default: x = {$urandom_range(0, 1) ? 9'h1FF : 9'h000,
                                  23'($urandom())};
                endcase
                send_operand(x, 31'd0, 1'b0);
                sent++;
            end
            // Hold the sender off for a random gap, sometimes none
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (error_count == 0 && pending_roots.size() == 0)
            $display("fast_float_square_root regression: pass");
        else
            $display("fast_float_square_root regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ffsr_pkg.sv
rtl/ffsr_if.sv
rtl/ffsr_stage.sv
rtl/fast_float_square_root.sv
bench/fast_float_square_root_test.sv
